@@ src/kmp_pkg.sv @@
// Shared constants and types for the streaming pattern matcher.
`timescale 1ns / 1ps

package kmp_pkg;

	// Configuration port: 64-bit registers at 8-byte strides
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 64;
	localparam int REG_IDX_W  = 2;

	localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

	localparam int PAT_BYTES = 16;
	localparam int BYTE_W    = 8;
	localparam int LEN_REG_W = 5;
	localparam int TEXT_W    = 8;
	localparam int COUNT_W   = 32;
	localparam int BYTE_VALS = 256;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] pat_bytes_t;

endpackage

@@ src/kmp_ifs.sv @@
// Valid/ready channel interfaces for text bytes and match results.
`timescale 1ns / 1ps

interface kmp_text_if import kmp_pkg::*;;
	logic              valid;
	logic              ready;
	logic [TEXT_W-1:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

interface kmp_match_if import kmp_pkg::*;;
	logic               valid;
	logic               ready;
	logic               match_found;
	logic [COUNT_W-1:0] match_start;

	modport source (output valid, output match_found, output match_start, input ready);
	modport sink (input valid, input match_found, input match_start, output ready);
endinterface

@@ src/kmp_stream_matcher.sv @@
// Top level of the streaming KMP pattern matcher with its transition memory.
`timescale 1ns / 1ps

// Streaming exact-pattern matcher (Knuth-Morris-Pratt automaton). Program the
// pattern through the APB port (pattern_low at 0x00, pattern_high at 0x08,
// pattern_length at 0x10), then stream text bytes on the text channel; every
// byte yields one request on the result channel carrying a match flag and the
// 0-based start of the occurrence it completes (overlaps included). The
// automaton lives in a 256-row transition memory addressed by the text byte;
// each row holds the next matched length for every current matched length, so
// the per-byte state update is a single select on the registered row. The
// block takes one byte per cycle while the result channel keeps up and the
// table is not being rebuilt. A result passes two registers: the row is read
// into s1 when its byte is accepted, and the state update loads the output
// register when s2 advances. After reset and after every configuration write
// the table is rebuilt: first the pattern's border matrix is derived, then the
// 256 rows are written, one per byte value; text ready stays low throughout.
// Matched length and byte count survive configuration writes and clear only
// on reset; the byte count saturates at all ones.
module kmp_stream_matcher import kmp_pkg::*; #(
	parameter int MAX_PATTERN_LEN = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// streams
	kmp_text_if.sink              text,
	kmp_match_if.source           result
);

	localparam int NS    = MAX_PATTERN_LEN + 1;     // automaton states 0..MAX
	localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);

	// table build sequencer codes
	localparam logic [1:0] ST_BORDER = 2'd0;
	localparam logic [1:0] ST_FILL   = 2'd1;
	localparam logic [1:0] ST_RUN    = 2'd2;

	typedef logic [NS-1:0][LEN_W-1:0] row_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [APB_DATA_W-1:0] pattern_low_q;
	logic [APB_DATA_W-1:0] pattern_high_q;
	logic [LEN_REG_W-1:0]  pattern_length_q;
	logic                  cfg_wr;
	logic [REG_IDX_W-1:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1 -: REG_IDX_W];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= LEN_REG_W'(1);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_PATTERN_LOW: begin
					pattern_low_q <= pwdata;
				end
				REG_PATTERN_HIGH: begin
					pattern_high_q <= pwdata;
				end
				REG_PATTERN_LENGTH: begin
					pattern_length_q <= pwdata[LEN_REG_W-1:0];
				end
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PATTERN_LOW:    prdata = pattern_low_q;
			REG_PATTERN_HIGH:   prdata = pattern_high_q;
			REG_PATTERN_LENGTH: prdata = APB_DATA_W'(pattern_length_q);
			default:            prdata = '0;
		endcase
	end

	// Effective pattern length: zero acts as one, oversize clamps to the max.
	logic [LEN_W-1:0] m_eff;
	pat_bytes_t       pat;

	assign pat = {pattern_high_q, pattern_low_q};

	always_comb begin
		if (pattern_length_q == '0) begin
			m_eff = LEN_W'(1);
		end else if (pattern_length_q > LEN_REG_W'(MAX_PATTERN_LEN)) begin
			m_eff = LEN_W'(MAX_PATTERN_LEN);
		end else begin
			m_eff = LEN_W'(pattern_length_q);
		end
	end

	// ------------------------------------------------------------------
	// Table build: border matrix, then one memory row per byte value
	// ------------------------------------------------------------------
	logic [1:0]                      state_q;
	logic [TEXT_W-1:0]               fill_q;
	logic [NS-1:0][MAX_PATTERN_LEN-1:0] bord_d;
	logic [NS-1:0][MAX_PATTERN_LEN-1:0] bord_q;
	row_t                            row_raw;
	row_t                            row_d;

	// bord[q][j]: the first j pattern bytes equal the j bytes ending at q,
	// so prefix j can extend a partial match of length q.
	always_comb begin
		logic hit;
		for (int q = 0; q < NS; q++) begin
			for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
				hit = (j <= q);
				for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
					if (i < j && j <= q) begin
						hit = hit && (pat[i] == pat[4'(q - j + i)]);
					end
				end
				bord_d[q][j] = hit;
			end
		end
	end

	// Next state for every current state on byte fill_q: the longest
	// prefix k whose first k-1 bytes border the match and whose last byte
	// is the incoming one.
	always_comb begin
		for (int q = 0; q < NS; q++) begin
			row_raw[q] = '0;
			for (int k = 1; k <= MAX_PATTERN_LEN; k++) begin
				if (k <= q + 1 && LEN_W'(k) <= m_eff && bord_q[q][k-1]
						&& pat[k-1] == fill_q) begin
					row_raw[q] = LEN_W'(k);
				end
			end
		end
		// a state above the pattern length behaves as the full length
		for (int q = 0; q < NS; q++) begin
			row_d[q] = (LEN_W'(q) > m_eff) ? row_raw[m_eff] : row_raw[q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BORDER;
			fill_q  <= '0;
		end else if (cfg_wr) begin
			// restart the build on any write
			state_q <= ST_BORDER;
			fill_q  <= '0;
		end else begin
			case (state_q)
				ST_BORDER: begin
					state_q <= ST_FILL;
					fill_q  <= '0;
				end
				ST_FILL: begin
					fill_q <= fill_q + TEXT_W'(1);
					if (fill_q == '1) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_BORDER;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_BORDER) begin
			bord_q <= bord_d;
		end
	end

	// ------------------------------------------------------------------
	// Transition memory: 256 rows, one write port (build), one read port
	// (text byte), registered read data
	// ------------------------------------------------------------------
	row_t mem [BYTE_VALS];
	row_t row_s1;
	logic in_acc;

	always_ff @(posedge clk) begin
		if (state_q == ST_FILL && !cfg_wr) begin
			mem[fill_q] <= row_d;
		end
		if (in_acc) begin
			row_s1 <= mem[text.text_byte];
		end
	end

	// ------------------------------------------------------------------
	// Stream pipeline: s1 holds the row read, s2 updates the state and
	// loads the output register
	// ------------------------------------------------------------------
	logic               valid_s1;
	logic               adv_s2;
	logic [LEN_W-1:0]   q_q;
	logic [COUNT_W-1:0] bytes_q;
	logic               out_valid_q;
	logic               found_q;
	logic [COUNT_W-1:0] start_q;
	logic [LEN_W-1:0]   q_nxt;
	logic [COUNT_W-1:0] bytes_nxt;
	logic               found_nxt;
	logic [COUNT_W-1:0] start_nxt;

	// advance s2 whenever the output register is empty or being drained
	assign adv_s2     = valid_s1 && (!out_valid_q || result.ready);
	assign text.ready = (state_q == ST_RUN) && (!valid_s1 || adv_s2);
	assign in_acc     = text.valid && text.ready;

	assign q_nxt     = row_s1[q_q];
	assign bytes_nxt = (bytes_q == COUNT_MAX) ? bytes_q : bytes_q + COUNT_W'(1);
	assign found_nxt = (q_nxt == m_eff);

	always_comb begin
		start_nxt = '0;
		if (found_nxt && bytes_nxt >= COUNT_W'(m_eff)) begin
			start_nxt = bytes_nxt - COUNT_W'(m_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			q_q         <= '0;
			bytes_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				q_q         <= q_nxt;
				bytes_q     <= bytes_nxt;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			found_q <= found_nxt;
			start_q <= start_nxt;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.match_found = found_q;
	assign result.match_start = start_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_no_text_during_build: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_RUN |-> !text.ready)
		else $error("text accepted while the transition table is rebuilt");

	a_state_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_q <= LEN_W'(MAX_PATTERN_LEN))
		else $error("matched length beyond the maximum pattern length");

	a_no_start_without_match: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.match_found |-> result.match_start == '0)
		else $error("start position reported without a match");

	a_count_advances: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && bytes_q != COUNT_MAX |=> bytes_q == $past(bytes_q) + COUNT_W'(1))
		else $error("byte count did not advance on a processed byte");

endmodule

@@ sim/tb_top.sv @@
// Testbench for the streaming KMP matcher: directed and random text checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
	import kmp_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 120;
	// margin left after the results drain, before a register write
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic               found;
		logic [COUNT_W-1:0] start;
	} match_rec_t;

	// receiver stall patterns
	typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	kmp_text_if  text_ch ();
	kmp_match_if match_ch ();

	kmp_stream_matcher u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.text    (text_ch),
		.result  (match_ch)
	);

	always #6 clk = ~clk;

	// Predictor copy of the configuration and the automaton state
	logic [63:0]          cfg_lo;
	logic [63:0]          cfg_hi;
	logic [LEN_REG_W-1:0] cfg_len;
	logic [LEN_REG_W-1:0] prefix_len;
	logic [COUNT_W-1:0]   byte_count;

	// Matches the block still owes us, oldest first
	match_rec_t pending_matches[$];

	int mismatch_cnt = 0;
	int cycle_cnt    = 0;
	int burst_left   = 0;
	bit gaps_en      = 1'b1;
	bit hold_req     = 1'b0;

	// Clamp the programmed length to 1..16
	function automatic int active_len();
		int m;
		m = int'(cfg_len);
		if (m < 1) m = 1;
		if (m > PAT_BYTES) m = PAT_BYTES;
		return m;
	endfunction

	function automatic logic [BYTE_W-1:0] pat_at(input int i);
		pat_bytes_t p;
		p = {cfg_hi, cfg_lo};
		return p[i & (PAT_BYTES - 1)];
	endfunction

	// Advance the automaton by one text byte and return the match it reports.
	// The next prefix length is the longest pattern prefix that is a suffix of
	// the current prefix followed by the new byte; a stale prefix longer than
	// the active length counts as the full length.
	function automatic match_rec_t step_matcher(input logic [BYTE_W-1:0] c);
		int             m;
		int             q;
		int             len;
		int             top;
		int             nxt;
		bit             ok;
		logic [BYTE_W-1:0] w[PAT_BYTES+1];
		match_rec_t     r;
		m = active_len();
		q = int'(prefix_len);
		if (q > m) q = m;
		for (int i = 0; i < q; i++) w[i] = pat_at(i);
		w[q] = c;
		len = q + 1;
		top = (len < m) ? len : m;
		nxt = 0;
		for (int k = top; k >= 1 && nxt == 0; k--) begin
			ok = 1'b1;
			for (int i = 0; i < k; i++)
				if (pat_at(i) != w[len-k+i]) ok = 1'b0;
			if (ok) nxt = k;
		end
		prefix_len = nxt[LEN_REG_W-1:0];
		// the count saturates at all ones
		if (byte_count != COUNT_MAX) byte_count++;
		r.found = (nxt == m);
		r.start = '0;
		if (r.found && byte_count >= m) r.start = byte_count - m;
		return r;
	endfunction

	// Watchdog: end the run if it hangs
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Compare every accepted result request with the oldest pending match
	always @(posedge clk) begin
		match_rec_t exp_rec;
		if (arst_n && match_ch.valid && match_ch.ready) begin
			if (pending_matches.size() == 0) begin
				$error("result with nothing pending: match_found %0d match_start %0d",
					match_ch.match_found, match_ch.match_start);
				mismatch_cnt++;
			end else begin
				exp_rec = pending_matches.pop_front();
				if (match_ch.match_found !== exp_rec.found) begin
					$error("match_found: expected %0d, got %0d",
						exp_rec.found, match_ch.match_found);
					mismatch_cnt++;
				end
				if (match_ch.match_start !== exp_rec.start) begin
					$error("match_start: expected %0d, got %0d",
						exp_rec.start, match_ch.match_start);
					mismatch_cnt++;
				end
			end
		end
	end

	// Receiver: switch among stall patterns in segments of random length.
	// A raised hold_req starts one long hold counted here.
	initial begin
		int       seg_left;
		int       hold_left;
		bit       hold_seen;
		rx_mode_e mode;
		match_ch.ready = 1'b0;
		seg_left  = 0;
		hold_left = 0;
		hold_seen = 1'b0;
		mode      = RX_STREAM;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_seen) hold_left = HOLD_CYCLES;
			hold_seen = hold_req;
			if (seg_left == 0) begin
				mode     = rx_mode_e'($urandom_range(0, 3));
				seg_left = $urandom_range(10, 80);
			end
			seg_left--;
			if (hold_left > 0) begin
				hold_left--;
				match_ch.ready <= 1'b0;
			end else begin
				case (mode)
					RX_STREAM: match_ch.ready <= 1'b1;
					RX_COIN: match_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: match_ch.ready <= (seg_left % 4 == 0);
					default: match_ch.ready <= (seg_left % 8 < 5);
				endcase
			end
		end
	end

	// Drop valid, then hold until every pending match has come back
	task automatic wait_drained();
		text_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_matches.size() != 0) @(negedge clk);
	endtask

	// Let the pipeline empty before touching a register
	task automatic settle();
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready
	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'({idx, 3'b000});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_PATTERN_LOW: cfg_lo = val;
			REG_PATTERN_HIGH: cfg_hi = val;
			REG_PATTERN_LENGTH: cfg_len = val[LEN_REG_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// bus goes idle between transfers
		@(negedge clk);
	endtask

	task automatic program_pattern(input logic [63:0] lo, input logic [63:0] hi,
		input logic [63:0] len);
		settle();
		apb_write(REG_PATTERN_LOW, lo);
		apb_write(REG_PATTERN_HIGH, hi);
		apb_write(REG_PATTERN_LENGTH, len);
	endtask

	// Offer one text byte; the sender works in bursts with random gaps.
	// Valid stays high into the next call so back-to-back bytes stream.
	task automatic send_text(input logic [TEXT_W-1:0] b);
		int gap;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_en ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				text_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		text_ch.valid     <= 1'b1;
		text_ch.text_byte <= b;
		do @(posedge clk); while (!text_ch.ready);
		pending_matches = {pending_matches, step_matcher(b)};
		burst_left--;
		@(negedge clk);
	endtask

	// Reset pattern is a single zero byte: zero matches, all ones does not
	task automatic test_reset_defaults();
		send_text(8'h00);
		send_text(8'hFF);
	endtask

	// Overlapping occurrences of "aa"
	task automatic test_overlap();
		program_pattern(64'h0000_0000_0000_6161, 64'h0, 64'd2);
		repeat (3) send_text(8'h61);
	endtask

	// Out-of-range length clamps to sixteen; all-ones pattern over all-ones text
	task automatic test_full_length();
		program_pattern('1, '1, 64'd31);
		repeat (17) send_text(8'hFF);
	endtask

	// Partial match of "abab", then shrink the length to zero (acts as one)
	// with the state kept, so the stale prefix caps to the new length
	task automatic test_midstream_change();
		program_pattern(64'h0000_0000_6261_6261, 64'h0, 64'd4);
		send_text(8'h61);
		send_text(8'h62);
		send_text(8'h61);
		settle();
		apb_write(REG_PATTERN_LENGTH, 64'd0);
		send_text(8'h61);
	endtask

	// Random patterns and lengths; text is mostly whole or broken copies of
	// the pattern, then single pattern bytes, then noise
	task automatic test_random_text(input int phases, input int per_phase);
		logic [63:0]       lo;
		logic [63:0]       hi;
		logic [63:0]       len;
		logic [BYTE_W-1:0] sym_a;
		logic [BYTE_W-1:0] sym_b;
		pat_bytes_t        p;
		int                m;
		int                sent;
		int                kind;
		int                r;
		for (int ph = 0; ph < phases; ph++) begin
			r = $urandom_range(0, 19);
			if (r < 2) len = 64'd16;
			else if (r == 2) len = 64'd0;
			else if (r == 3) len = 64'($urandom_range(17, 31));
			else len = 64'($urandom_range(1, 6));
			// upper bits of the length register are ignored; toggle them too
			if ($urandom_range(0, 3) == 0)
				len[63:LEN_REG_W] = (64 - LEN_REG_W)'({$urandom, $urandom});
			lo = {$urandom, $urandom};
			hi = {$urandom, $urandom};
			// a two-symbol alphabet makes self-overlapping patterns likely
			if ($urandom_range(0, 1)) begin
				sym_a = BYTE_W'($urandom_range(0, 255));
				sym_b = BYTE_W'($urandom_range(0, 255));
				for (int i = 0; i < PAT_BYTES; i++)
					p[i] = $urandom_range(0, 1) ? sym_a : sym_b;
				{hi, lo} = p;
			end
			program_pattern(lo, hi, len);
			m = active_len();
			sent = 0;
			while (sent < per_phase) begin
				kind = $urandom_range(0, 9);
				if (kind < 6) begin
					for (int i = 0; i < m - 1; i++) send_text(pat_at(i));
					if ($urandom_range(0, 3) == 0) send_text(TEXT_W'($urandom_range(0, 255)));
					else send_text(pat_at(m - 1));
					sent += m;
				end else if (kind < 9) begin
					send_text(pat_at($urandom_range(0, m - 1)));
					sent++;
				end else begin
					send_text(TEXT_W'($urandom_range(0, 255)));
					sent++;
				end
			end
		end
	endtask

	// Long receiver hold while bytes keep coming, then pause until drained
	task automatic test_backpressure();
		program_pattern(64'h0000_0000_0000_6261, 64'h0, 64'd2);
		gaps_en  = 1'b0;
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++) send_text($urandom_range(0, 1) ? 8'h61 : 8'h62);
		hold_req = 1'b0;
		gaps_en  = 1'b1;
		wait_drained();
	endtask

	initial begin
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		text_ch.valid     = 1'b0;
		text_ch.text_byte = '0;
		cfg_lo            = '0;
		cfg_hi            = '0;
		cfg_len           = 5'd1;
		prefix_len        = '0;
		byte_count        = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_overlap();
		test_full_length();
		test_midstream_change();
		test_backpressure();
		test_random_text(8, 50);

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_cnt == 0 && pending_matches.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/kmp_pkg.sv
src/kmp_ifs.sv
src/kmp_stream_matcher.sv
sim/tb_top.sv
